>>> design/bfz_pkg.sv
package bfz_pkg;

   // Fixed canvas and source limits
   localparam int CANVAS_W       = 1280;
   localparam int CANVAS_H       = 720;
   localparam int MAX_SOURCE_DIM = 2048;

   // Datapath widths
   localparam int DIM_W      = 12;   // saturated width / height
   localparam int IX_W       = 11;   // pixel column / row inside the source
   localparam int INV_W      = 18;   // inverse scale, Q16
   localparam int ORG_W      = 20;   // canvas origin, Q4, signed
   localparam int D_W        = 20;   // pixel center minus origin, Q4, signed
   localparam int LIN_W      = 24;   // linear source position
   localparam int PIX_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   // Rounding bias for the premultiply: 255 * 2^31
   localparam logic [48:0] RND_BIAS = 49'(255) << 31;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_W = 3'd0,
      CSR_SRC_H = 3'd1,
      CSR_ZOOM  = 3'd2,
      CSR_PAN_X = 3'd3,
      CSR_PAN_Y = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_PREP,
      ST_DIV,
      ST_IDLE
   } setup_state_type;

   // Derived configuration; the user keeps it stable while items are in flight, not enforced
   typedef struct packed {
      logic [DIM_W-1:0]        w;
      logic [DIM_W-1:0]        h;
      logic [LIN_W-1:0]        wh;
      logic [INV_W-1:0]        inv;
      logic signed [ORG_W-1:0] org_x;
      logic signed [ORG_W-1:0] org_y;
   } cfg_type;

   // Per item control carried down the address pipeline
   typedef struct packed {
      logic             valid;
      logic             render;
      logic             wr_ok;
      logic [LIN_W-1:0] wr_idx;
      logic [PIX_W-1:0] pix;
   } ctl_type;

   // Request to the pixel store
   typedef struct packed {
      ctl_type          ctl;
      logic             in_img;
      logic [7:0]       wx;
      logic [7:0]       wy;
      logic [LIN_W-1:0] a00;
      logic [LIN_W-1:0] a10;
      logic [LIN_W-1:0] a01;
      logic [LIN_W-1:0] a11;
      logic [3:0]       zero;
   } memreq_type;

   // Four neighbors read from the store
   typedef struct packed {
      logic                  valid;
      logic                  render;
      logic                  in_img;
      logic [7:0]            wx;
      logic [7:0]            wy;
      logic [3:0]            zero;
      logic [3:0][PIX_W-1:0] px;
   } pixq_type;

   // Finished output pixel
   typedef struct packed {
      logic       valid;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       in_img;
   } res_type;

endpackage

>>> design/bilinear_fit_zoom_pan_scaler.sv
// Bilinear fit / zoom / pan scaler.
// req_ channel: one item per cycle unless stalled. req_action 0 loads one RGBA
// source pixel at req_load_index; loads past width*height are dropped and
// give no response. req_action 1 renders canvas pixel (req_out_col, req_out_row)
// and gives exactly one rsp_ item with premultiplied color and rsp_inside_res.
// csr_ channel: register writes (width, height, zoom, pan x, pan y), to be
// written only while no item is in flight.
// Throughput: one item per clock unless stalled; the four neighbors come from
// two store copies, each with two read ports, so a render never waits on the
// store. A render passes the map, store, blend and output registers before it
// shows on rsp_valid. After reset and after every csr write, req_stall is high
// while the inverse scale is found by a one-bit-per-cycle restoring divider.
// The source store is not cleared; pixels must be loaded before they are used.
// When rsp_stall holds a result, one more result goes to a skid register and
// then the whole pipeline freezes and req_stall rises until the result is taken.
module bilinear_fit_zoom_pan_scaler #(
   parameter int SOURCE_PIXELS = 1048576
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic [19:0]                    req_load_index,
   input  logic [7:0]                     req_red_in,
   input  logic [7:0]                     req_green_in,
   input  logic [7:0]                     req_blue_in,
   input  logic [7:0]                     req_alpha_in,
   input  logic [10:0]                    req_out_col,
   input  logic [9:0]                     req_out_row,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_red_out,
   output logic [7:0]                     rsp_green_out,
   output logic [7:0]                     rsp_blue_out,
   output logic                           rsp_inside_res,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bfz_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfz_pkg::CSR_DATA_W-1:0] csr_data
);
   import bfz_pkg::*;

   cfg_type    cfg;
   memreq_type mreq;
   pixq_type   pq;
   res_type    bo;
   logic       busy, adv, accept, take;

   res_type    rsp_ff, skid_ff;
   logic       rsp_valid_ff, skid_full_ff;

   // Pipeline moves unless the skid register holds a result
   assign adv       = !skid_full_ff;
   assign req_stall = !adv || busy;
   assign accept    = req_valid && !req_stall;
   assign take      = rsp_valid_ff && !rsp_stall;

   bfz_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .cfg       (cfg),
      .busy      (busy)
   );

   bfz_map #(.SOURCE_PIXELS(SOURCE_PIXELS)) u_map (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .accept     (accept),
      .action     (req_action),
      .load_index (req_load_index),
      .pix        ({req_alpha_in, req_blue_in, req_green_in, req_red_in}),
      .out_col    (req_out_col),
      .out_row    (req_out_row),
      .cfg        (cfg),
      .req        (mreq)
   );

   bfz_store #(.SOURCE_PIXELS(SOURCE_PIXELS)) u_store (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .req   (mreq),
      .rd    (pq)
   );

   bfz_blend u_blend (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .rd    (pq),
      .res   (bo)
   );

   // Output register with skid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (take) begin
            skid_full_ff <= 1'b0;
         end
      end else if (bo.valid) begin
         if (rsp_valid_ff && !take) begin
            skid_full_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b1;
         end
      end else if (take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (take) rsp_ff <= skid_ff;
      end else if (bo.valid) begin
         if (rsp_valid_ff && !take) skid_ff <= bo;
         else                       rsp_ff  <= bo;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_out    = rsp_ff.red;
   assign rsp_green_out  = rsp_ff.green;
   assign rsp_blue_out   = rsp_ff.blue;
   assign rsp_inside_res = rsp_ff.in_img;

   // Skid holds a result only behind a waiting output
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> rsp_valid_ff)
      else $error("skid full with empty output register");

   // Pixels outside the image are black
   a_outside_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_inside_res) |->
         (rsp_red_out == 8'd0 && rsp_green_out == 8'd0 && rsp_blue_out == 8'd0))
      else $error("outside pixel not black");

   // A register write blocks items until the derived values are ready
   a_cfg_blocks: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> req_stall)
      else $error("item accepted during setup");

endmodule

>>> design/bfz_setup.sv
module bfz_setup (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [bfz_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfz_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                           csr_ready,
   output bfz_pkg::cfg_type               cfg,
   output logic                           busy
);
   import bfz_pkg::*;

   localparam int CNT_W = $clog2(INV_W);

   logic [DIM_W-1:0]      src_w_ff, src_h_ff;
   logic [15:0]           zoom_ff;
   logic [17:0]           pan_x_ff, pan_y_ff;
   setup_state_type       state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff;
   logic [35:0]           rem_ff, den_ff;
   logic [INV_W-1:0]      quo_ff;
   logic [DIM_W-1:0]      w_ff, h_ff;
   logic [LIN_W-1:0]      wh_ff;
   logic signed [ORG_W-1:0] org_x_ff, org_y_ff;

   logic [DIM_W-1:0] w_sat, h_sat;
   logic [15:0]      z_sat;
   logic [21:0]      m_a, m_b, m_max;
   logic [35:0]      den;
   logic [36:0]      shifted;
   logic             ge;
   logic             wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   // Register saturation, larger cross product and divisor
   always_comb begin
      w_sat = (src_w_ff == '0) ? DIM_W'(1) :
              (src_w_ff > DIM_W'(MAX_SOURCE_DIM)) ? DIM_W'(MAX_SOURCE_DIM) : src_w_ff;
      h_sat = (src_h_ff == '0) ? DIM_W'(1) :
              (src_h_ff > DIM_W'(MAX_SOURCE_DIM)) ? DIM_W'(MAX_SOURCE_DIM) : src_h_ff;
      z_sat = (zoom_ff < 16'd4096) ? 16'd4096 :
              (zoom_ff > 16'd32768) ? 16'd32768 : zoom_ff;
      m_a   = 22'(w_sat) * 22'(CANVAS_H);
      m_b   = 22'(h_sat) * 22'(CANVAS_W);
      m_max = (m_a > m_b) ? m_a : m_b;
      den   = 36'(z_sat) * 36'(CANVAS_W * CANVAS_H);
   end

   // One restoring division step; low dividend bits are all zero
   assign shifted = {rem_ff, 1'b0};
   assign ge      = shifted >= {1'b0, den_ff};

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= DIM_W'(1280);
         src_h_ff <= DIM_W'(720);
         zoom_ff  <= 16'd4096;
         pan_x_ff <= '0;
         pan_y_ff <= '0;
      end else if (wr) begin
         case (csr_index_type'(csr_index))
            CSR_SRC_W: src_w_ff <= csr_data[DIM_W-1:0];
            CSR_SRC_H: src_h_ff <= csr_data[DIM_W-1:0];
            CSR_ZOOM:  zoom_ff  <= csr_data[15:0];
            CSR_PAN_X: pan_x_ff <= csr_data;
            CSR_PAN_Y: pan_y_ff <= csr_data;
            default:   ;
         endcase
      end
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_PREP;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_PREP: state_in = ST_DIV;
         ST_DIV:  if (cnt_ff == '0) state_in = ST_IDLE;
         ST_IDLE: state_in = ST_IDLE;
         default: state_in = ST_PREP;
      endcase
      if (wr) state_in = ST_PREP;
      busy = (state_ff != ST_IDLE);
   end

   // Derived values and divider datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_PREP: begin
            w_ff     <= w_sat;
            h_ff     <= h_sat;
            wh_ff    <= LIN_W'(w_sat) * LIN_W'(h_sat);
            org_x_ff <= ORG_W'(CANVAS_W * 8) + {{(ORG_W-18){pan_x_ff[17]}}, pan_x_ff};
            org_y_ff <= ORG_W'(CANVAS_H * 8) + {{(ORG_W-18){pan_y_ff[17]}}, pan_y_ff};
            den_ff   <= den;
            rem_ff   <= 36'(m_max) << 10;
            cnt_ff   <= CNT_W'(INV_W - 1);
         end
         ST_DIV: begin
            rem_ff <= ge ? 36'(shifted - {1'b0, den_ff}) : shifted[35:0];
            quo_ff <= {quo_ff[INV_W-2:0], ge};
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
         default: ;
      endcase
   end

   assign cfg.w     = w_ff;
   assign cfg.h     = h_ff;
   assign cfg.wh    = wh_ff;
   assign cfg.inv   = quo_ff;
   assign cfg.org_x = org_x_ff;
   assign cfg.org_y = org_y_ff;

endmodule

>>> design/bfz_map.sv
module bfz_map #(
   parameter int SOURCE_PIXELS = 1048576
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           accept,
   input  logic                           action,
   input  logic [19:0]                    load_index,
   input  logic [bfz_pkg::PIX_W-1:0]      pix,
   input  logic [10:0]                    out_col,
   input  logic [9:0]                     out_row,
   input  bfz_pkg::cfg_type               cfg,
   output bfz_pkg::memreq_type            req
);
   import bfz_pkg::*;

   ctl_type ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff;
   logic signed [D_W-1:0]  dx1_ff, dy1_ff;
   logic signed [38:0]     px2_ff, py2_ff;
   logic                   in3_ff, in4_ff;
   logic [IX_W-1:0]        x0_3_ff, x1_3_ff, y0_3_ff, y1_3_ff, x0_4_ff, x1_4_ff;
   logic [7:0]             wx3_ff, wy3_ff, wx4_ff, wy4_ff;
   logic [22:0]            r0_4_ff, r1_4_ff;
   memreq_type             req_ff;

   ctl_type                ctl0;
   logic [20:0]            dx_full, dy_full;
   logic signed [35:0]     sx, sy;
   logic                   in_x, in_y;
   logic [IX_W-1:0]        x0, y0, x1, y1;
   logic [LIN_W-1:0]       l00, l10, l01, l11;

   // Stage 1: pixel center minus origin, load range check
   always_comb begin
      ctl0.valid  = accept;
      ctl0.render = action;
      ctl0.wr_idx = LIN_W'(load_index);
      ctl0.wr_ok  = (LIN_W'(load_index) < cfg.wh) &&
                    (LIN_W'(load_index) < LIN_W'(SOURCE_PIXELS));
      ctl0.pix    = pix;
      dx_full = {6'b0, out_col, 1'b1, 3'b0} - {cfg.org_x[ORG_W-1], cfg.org_x};
      dy_full = {7'b0, out_row, 1'b1, 3'b0} - {cfg.org_y[ORG_W-1], cfg.org_y};
   end

   // Stage 3: source coordinate, inside test, neighbors and weights
   always_comb begin
      sx = $signed({px2_ff[38], px2_ff[38:4]}) + $signed({9'b0, cfg.w - DIM_W'(1), 15'b0});
      sy = $signed({py2_ff[38], py2_ff[38:4]}) + $signed({9'b0, cfg.h - DIM_W'(1), 15'b0});
      in_x = !sx[35] && (sx[34:0] <= 35'({cfg.w - DIM_W'(1), 16'b0}));
      in_y = !sy[35] && (sy[34:0] <= 35'({cfg.h - DIM_W'(1), 16'b0}));
      x0 = sx[16 +: IX_W];
      y0 = sy[16 +: IX_W];
      x1 = (DIM_W'(x0) == cfg.w - DIM_W'(1)) ? x0 : x0 + IX_W'(1);
      y1 = (DIM_W'(y0) == cfg.h - DIM_W'(1)) ? y0 : y0 + IX_W'(1);
   end

   // Stage 5: linear neighbor positions
   always_comb begin
      l00 = LIN_W'(r0_4_ff) + LIN_W'(x0_4_ff);
      l10 = LIN_W'(r0_4_ff) + LIN_W'(x1_4_ff);
      l01 = LIN_W'(r1_4_ff) + LIN_W'(x0_4_ff);
      l11 = LIN_W'(r1_4_ff) + LIN_W'(x1_4_ff);
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid    <= 1'b0;
         ctl2_ff.valid    <= 1'b0;
         ctl3_ff.valid    <= 1'b0;
         ctl4_ff.valid    <= 1'b0;
         req_ff.ctl.valid <= 1'b0;
      end else if (adv) begin
         ctl1_ff.valid    <= ctl0.valid;
         ctl2_ff.valid    <= ctl1_ff.valid;
         ctl3_ff.valid    <= ctl2_ff.valid;
         ctl4_ff.valid    <= ctl3_ff.valid;
         req_ff.ctl.valid <= ctl4_ff.valid;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         {ctl1_ff.render, ctl1_ff.wr_ok, ctl1_ff.wr_idx, ctl1_ff.pix} <=
            {ctl0.render, ctl0.wr_ok, ctl0.wr_idx, ctl0.pix};
         {ctl2_ff.render, ctl2_ff.wr_ok, ctl2_ff.wr_idx, ctl2_ff.pix} <=
            {ctl1_ff.render, ctl1_ff.wr_ok, ctl1_ff.wr_idx, ctl1_ff.pix};
         {ctl3_ff.render, ctl3_ff.wr_ok, ctl3_ff.wr_idx, ctl3_ff.pix} <=
            {ctl2_ff.render, ctl2_ff.wr_ok, ctl2_ff.wr_idx, ctl2_ff.pix};
         {ctl4_ff.render, ctl4_ff.wr_ok, ctl4_ff.wr_idx, ctl4_ff.pix} <=
            {ctl3_ff.render, ctl3_ff.wr_ok, ctl3_ff.wr_idx, ctl3_ff.pix};
         {req_ff.ctl.render, req_ff.ctl.wr_ok, req_ff.ctl.wr_idx, req_ff.ctl.pix} <=
            {ctl4_ff.render, ctl4_ff.wr_ok, ctl4_ff.wr_idx, ctl4_ff.pix};

         dx1_ff <= dx_full[D_W-1:0];
         dy1_ff <= dy_full[D_W-1:0];

         px2_ff <= dx1_ff * $signed({1'b0, cfg.inv});
         py2_ff <= dy1_ff * $signed({1'b0, cfg.inv});

         in3_ff  <= in_x && in_y;
         x0_3_ff <= x0;
         x1_3_ff <= x1;
         y0_3_ff <= y0;
         y1_3_ff <= y1;
         wx3_ff  <= sx[15:8];
         wy3_ff  <= sy[15:8];

         in4_ff  <= in3_ff;
         x0_4_ff <= x0_3_ff;
         x1_4_ff <= x1_3_ff;
         wx4_ff  <= wx3_ff;
         wy4_ff  <= wy3_ff;
         r0_4_ff <= 23'(y0_3_ff) * 23'(cfg.w);
         r1_4_ff <= 23'(y1_3_ff) * 23'(cfg.w);

         req_ff.in_img <= in4_ff;
         req_ff.wx     <= wx4_ff;
         req_ff.wy     <= wy4_ff;
         req_ff.a00    <= l00;
         req_ff.a10    <= l10;
         req_ff.a01    <= l01;
         req_ff.a11    <= l11;
         req_ff.zero   <= {l11 >= LIN_W'(SOURCE_PIXELS), l01 >= LIN_W'(SOURCE_PIXELS),
                           l10 >= LIN_W'(SOURCE_PIXELS), l00 >= LIN_W'(SOURCE_PIXELS)};
      end
   end

   assign req = req_ff;

endmodule

>>> design/bfz_store.sv
module bfz_store #(
   parameter int SOURCE_PIXELS = 1048576
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  bfz_pkg::memreq_type req,
   output bfz_pkg::pixq_type   rd
);
   import bfz_pkg::*;

   localparam int ADDR_W = $clog2(SOURCE_PIXELS);

   // Two copies, each with one write and two read ports: top row and bottom row
   logic [PIX_W-1:0] mem_top [SOURCE_PIXELS];
   logic [PIX_W-1:0] mem_bot [SOURCE_PIXELS];

   logic [PIX_W-1:0] p00_ff, p10_ff, p01_ff, p11_ff;
   logic             valid_ff, render_ff, inside_ff;
   logic [7:0]       wx_ff, wy_ff;
   logic [3:0]       zero_ff;
   logic             we;
   logic [ADDR_W-1:0] waddr;

   // Loads and renders pass in order, so a read always sees earlier writes
   assign we    = adv && req.ctl.valid && !req.ctl.render && req.ctl.wr_ok;
   assign waddr = req.ctl.wr_idx[ADDR_W-1:0];

   // Top row copy
   always_ff @(posedge clock) begin
      if (we) mem_top[waddr] <= req.ctl.pix;
      if (adv) begin
         p00_ff <= mem_top[req.a00[ADDR_W-1:0]];
         p10_ff <= mem_top[req.a10[ADDR_W-1:0]];
      end
   end

   // Bottom row copy
   always_ff @(posedge clock) begin
      if (we) mem_bot[waddr] <= req.ctl.pix;
      if (adv) begin
         p01_ff <= mem_bot[req.a01[ADDR_W-1:0]];
         p11_ff <= mem_bot[req.a11[ADDR_W-1:0]];
      end
   end

   // Control alongside the read data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= req.ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         render_ff <= req.ctl.render;
         inside_ff <= req.in_img;
         wx_ff     <= req.wx;
         wy_ff     <= req.wy;
         zero_ff   <= req.zero;
      end
   end

   assign rd.valid  = valid_ff;
   assign rd.render = render_ff;
   assign rd.in_img = inside_ff;
   assign rd.wx     = wx_ff;
   assign rd.wy     = wy_ff;
   assign rd.zero   = zero_ff;
   assign rd.px     = {p11_ff, p01_ff, p10_ff, p00_ff};

endmodule

>>> design/bfz_blend.sv
module bfz_blend (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  bfz_pkg::pixq_type rd,
   output bfz_pkg::res_type  res
);
   import bfz_pkg::*;

   localparam int NST = 5;

   logic [NST-1:0] v_ff, r_ff, in_ff;
   logic [7:0]     wy1_ff;
   logic [3:0][15:0] top1_ff, bot1_ff;
   logic [3:0][23:0] v2_ff;
   logic [2:0][47:0] p3_ff;
   logic [2:0][16:0] u4_ff;
   logic [2:0][7:0]  o5_ff;

   logic [3:0][15:0] top, bot;
   logic [3:0][23:0] vv;
   logic [2:0][16:0] u;
   logic [2:0][7:0]  o;
   logic [3:0][7:0]  c00, c10, c01, c11;
   logic [8:0]       wxc, wyc;
   logic [48:0]      ysum;
   logic [25:0]      e;
   logic [9:0]       q0, q;
   logic [17:0]      rem;

   // Horizontal blend of both rows, unloadable neighbors read as zero
   always_comb begin
      wxc = 9'd256 - {1'b0, rd.wx};
      for (int c = 0; c < 4; c++) begin
         c00[c] = rd.zero[0] ? 8'd0 : rd.px[0][8*c +: 8];
         c10[c] = rd.zero[1] ? 8'd0 : rd.px[1][8*c +: 8];
         c01[c] = rd.zero[2] ? 8'd0 : rd.px[2][8*c +: 8];
         c11[c] = rd.zero[3] ? 8'd0 : rd.px[3][8*c +: 8];
         top[c] = 16'(17'(c00[c]) * 17'(wxc) + 17'(c10[c]) * 17'(rd.wx));
         bot[c] = 16'(17'(c01[c]) * 17'(wxc) + 17'(c11[c]) * 17'(rd.wx));
      end
   end

   // Vertical blend
   always_comb begin
      wyc = 9'd256 - {1'b0, wy1_ff};
      for (int c = 0; c < 4; c++) begin
         vv[c] = 24'(top1_ff[c]) * 24'(wyc) + 24'(bot1_ff[c]) * 24'(wy1_ff);
      end
   end

   // Rounding bias, then drop the 2^32 part of the divisor
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         ysum = 49'(p3_ff[c]) + RND_BIAS;
         u[c] = ysum[48:32];
      end
   end

   // Divide by 255: reciprocal estimate, one correction, clamp
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         e   = 26'(u4_ff[c]) * 26'(257);
         q0  = e[25:16];
         rem = 18'(u4_ff[c]) - 18'(q0) * 18'(255);
         q   = (rem >= 18'(255)) ? q0 + 10'd1 : q0;
         o[c] = (q > 10'd255) ? 8'hFF : q[7:0];
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NST-2:0], rd.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff    <= {r_ff[NST-2:0], rd.render};
         in_ff   <= {in_ff[NST-2:0], rd.in_img};
         wy1_ff  <= rd.wy;
         top1_ff <= top;
         bot1_ff <= bot;
         v2_ff   <= vv;
         for (int c = 0; c < 3; c++) begin
            p3_ff[c] <= 48'(v2_ff[c]) * 48'(v2_ff[3]);
         end
         u4_ff   <= u;
         o5_ff   <= o;
      end
   end

   // Outside pixels come out black
   assign res.valid  = v_ff[NST-1] && r_ff[NST-1];
   assign res.in_img = in_ff[NST-1];
   assign res.red    = in_ff[NST-1] ? o5_ff[0] : 8'd0;
   assign res.green  = in_ff[NST-1] ? o5_ff[1] : 8'd0;
   assign res.blue   = in_ff[NST-1] ? o5_ff[2] : 8'd0;

endmodule

>>> dv/tb_bilinear_fit_zoom_pan_scaler.sv
`timescale 1ns / 1ps

module tb_bilinear_fit_zoom_pan_scaler;
   import bfz_pkg::*;

   localparam int STORE_DEPTH = 1048576;
   localparam int DRAIN_WAIT  = 24;      // pipeline latency plus margin
   localparam int IDLE_LIMIT  = 5000;    // cycles without any handshake
   localparam int HOLD_CYCLES = 300;

   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd6;

   typedef enum logic {
      ACT_LOAD   = 1'b0,
      ACT_RENDER = 1'b1
   } action_type;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       in_img;
   } pixel_out_type;

   // ---------------------------------------------------------------
   // Scaler scoreboard: own copy of registers, store and pixel math
   // ---------------------------------------------------------------
   class scaler_scoreboard;
      bit [31:0]     pix_store[int unsigned];
      pixel_out_type pixel_queue[$];
      logic [11:0]   reg_w, reg_h;
      logic [15:0]   reg_zoom;
      logic [17:0]   reg_pan_x, reg_pan_y;
      longint        w, h, inv, org_x, org_y;
      int            errors, renders, loads, inside_hits;

      function new();
         reg_w     = 12'd1280;
         reg_h     = 12'd720;
         reg_zoom  = 16'd4096;
         reg_pan_x = '0;
         reg_pan_y = '0;
         rederive();
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function void rederive();
         longint z, ma, mb;
         w  = clip(reg_w, 1, MAX_SOURCE_DIM);
         h  = clip(reg_h, 1, MAX_SOURCE_DIM);
         z  = clip(reg_zoom, 4096, 32768);
         ma = w * CANVAS_H;
         mb = h * CANVAS_W;
         inv   = ((ma > mb ? ma : mb) << 28) / (longint'(CANVAS_W) * CANVAS_H * z);
         org_x = CANVAS_W * 8 + longint'($signed(reg_pan_x));
         org_y = CANVAS_H * 8 + longint'($signed(reg_pan_y));
      endfunction

      function void cfg_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SRC_W: reg_w     = data[11:0];
            CSR_SRC_H: reg_h     = data[11:0];
            CSR_ZOOM:  reg_zoom  = data[15:0];
            CSR_PAN_X: reg_pan_x = data;
            CSR_PAN_Y: reg_pan_y = data;
            default:   return;
         endcase
         rederive();
      endfunction

      // canvas position to Q16 source coordinate on one axis
      function longint to_source(longint p, longint org, longint n);
         longint d;
         d = (p * 2 + 1) * 8 - org;
         return ((d * inv) >>> 4) + (n - 1) * 32768;
      endfunction

      // neighbor positions and weights; returns 1 when inside the image
      function bit locate(int col, int row, output longint nb[4], output longint wx,
                          output longint wy);
         longint sx, sy, x0, y0, x1, y1;
         sx = to_source(col, org_x, w);
         sy = to_source(row, org_y, h);
         nb = '{default: 0};
         wx = 0;
         wy = 0;
         if (sx < 0 || sy < 0 || sx > (w - 1) * 65536 || sy > (h - 1) * 65536)
            return 0;
         x0 = sx >> 16;
         y0 = sy >> 16;
         x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
         y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
         wx = (sx >> 8) & 255;
         wy = (sy >> 8) & 255;
         nb[0] = y0 * w + x0;
         nb[1] = y0 * w + x1;
         nb[2] = y1 * w + x0;
         nb[3] = y1 * w + x1;
         return 1;
      endfunction

      function bit [31:0] fetch(longint idx);
         if (idx >= STORE_DEPTH || !pix_store.exists(idx))
            return '0;
         return pix_store[idx];
      endfunction

      // accepted input item
      function void note_item(action_type act, logic [19:0] idx, bit [31:0] rgba,
                              int col, int row);
         longint        nb[4], wx, wy, vt, vb, vc[4], r;
         bit [31:0]     p[4];
         pixel_out_type res;
         if (act == ACT_LOAD) begin
            loads++;
            if (idx < w * h && idx < STORE_DEPTH)
               pix_store[idx] = rgba;
            return;
         end
         renders++;
         res = '{red: 0, green: 0, blue: 0, in_img: 0};
         if (locate(col, row, nb, wx, wy)) begin
            inside_hits++;
            for (int k = 0; k < 4; k++)
               p[k] = fetch(nb[k]);
            for (int c = 0; c < 4; c++) begin
               vt = p[0][c*8 +: 8] * (256 - wx) + p[1][c*8 +: 8] * wx;
               vb = p[2][c*8 +: 8] * (256 - wx) + p[3][c*8 +: 8] * wx;
               vc[c] = vt * (256 - wy) + vb * wy;
            end
            for (int c = 0; c < 3; c++) begin
               r = (vc[c] * vc[3] + 255 * 64'h8000_0000) / (255 * 64'h1_0000_0000);
               if (r > 255) r = 255;
               if (c == 0) res.red = r[7:0];
               else if (c == 1) res.green = r[7:0];
               else res.blue = r[7:0];
            end
            res.in_img = 1;
         end
         pixel_queue.push_back(res);
      endfunction

      // accepted result item
      function void check_result(pixel_out_type got);
         pixel_out_type want;
         if (pixel_queue.size() == 0) begin
            $display("%0t: unexpected pixel r=%0d g=%0d b=%0d in=%0d", $time,
                     got.red, got.green, got.blue, got.in_img);
            errors++;
            return;
         end
         want = pixel_queue.pop_front();
         if (got.red !== want.red) begin
            $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
            errors++;
         end
         if (got.green !== want.green) begin
            $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
            errors++;
         end
         if (got.blue !== want.blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
            errors++;
         end
         if (got.in_img !== want.in_img) begin
            $display("%0t: inside expected %0d actual %0d", $time, want.in_img, got.in_img);
            errors++;
         end
      endfunction
   endclass

   logic                  clock, reset;
   logic                  req_valid, req_stall, req_action;
   logic [19:0]           req_load_index;
   logic [7:0]            req_red_in, req_green_in, req_blue_in, req_alpha_in;
   logic [10:0]           req_out_col;
   logic [9:0]            req_out_row;
   logic                  rsp_valid, rsp_stall;
   logic [7:0]            rsp_red_out, rsp_green_out, rsp_blue_out;
   logic                  rsp_inside_res;
   logic                  csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   scaler_scoreboard sb;
   int  burst_left, csr_writes, idle_cycles;
   bit  hold_rsp;

   bilinear_fit_zoom_pan_scaler uut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // bytes lean toward the extremes
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   // offer one item, return once it is taken
   task automatic send_item(action_type act, logic [19:0] idx, bit [31:0] rgba,
                            int col, int row);
      if (burst_left == 0) begin
         @(negedge clock);
         req_valid <= 0;
         repeat ($urandom_range(0, 1) ? $urandom_range(1, 8) : 0) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      else
         @(negedge clock);
      burst_left--;
      req_valid      <= 1;
      req_action     <= act;
      req_load_index <= idx;
      req_red_in     <= rgba[7:0];
      req_green_in   <= rgba[15:8];
      req_blue_in    <= rgba[23:16];
      req_alpha_in   <= rgba[31:24];
      req_out_col    <= 11'(col);
      req_out_row    <= 10'(row);
      do @(posedge clock); while (req_stall);
      sb.note_item(act, idx, rgba, col, row);
   endtask

   task automatic send_load(longint idx);
      send_item(ACT_LOAD, 20'(idx), {pick_byte(), pick_byte(), pick_byte(), pick_byte()},
                $urandom_range(0, 2047), $urandom_range(0, 1023));
   endtask

   // load whatever neighbors are still missing, then render
   task automatic render_pixel(int col, int row);
      longint nb[4], wx, wy;
      if (sb.locate(col, row, nb, wx, wy))
         for (int k = 0; k < 4; k++)
            if (nb[k] < STORE_DEPTH && !sb.pix_store.exists(nb[k]))
               send_load(nb[k]);
      send_item(ACT_RENDER, 20'($urandom), $urandom, col, row);
   endtask

   // render without loading, only when no unwritten entry would be read
   task automatic render_if_loaded(int col, int row);
      longint nb[4], wx, wy;
      bit     ok;
      ok = 1;
      if (sb.locate(col, row, nb, wx, wy))
         for (int k = 0; k < 4; k++)
            if (nb[k] < STORE_DEPTH && !sb.pix_store.exists(nb[k]))
               ok = 0;
      if (ok)
         send_item(ACT_RENDER, 20'($urandom), $urandom, col, row);
   endtask

   // wait until every pixel is back and the pipeline is quiet
   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      burst_left = 0;
      while (sb.pixel_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.cfg_write(idx, data);
      csr_writes++;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic configure(int wd, int ht, int zm, int px, int py);
      csr_write(CSR_SRC_W, CSR_DATA_W'(wd));
      csr_write(CSR_SRC_H, CSR_DATA_W'(ht));
      csr_write(CSR_ZOOM, CSR_DATA_W'(zm));
      csr_write(CSR_PAN_X, CSR_DATA_W'(px));
      csr_write(CSR_PAN_Y, CSR_DATA_W'(py));
   endtask

   // random traffic: mostly load-then-render sequences, some noise
   task automatic random_phase(int count);
      int col, row;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            col = $urandom_range(0, 2047);
            row = $urandom_range(0, 1023);
         end
         else begin
            col = $urandom_range(0, CANVAS_W - 1);
            row = $urandom_range(0, CANVAS_H - 1);
         end
         case ($urandom_range(0, 9))
            0, 1: send_load($urandom_range(0, 1) ? longint'($urandom & 20'hFFFFF)
                                                  : longint'($urandom_range(0, 15)));
            2:    render_if_loaded(col, row);
            default: render_pixel(col, row);
         endcase
      end
   endtask

   // result side: sample at rising edge
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{red: rsp_red_out, green: rsp_green_out, blue: rsp_blue_out,
                           in_img: rsp_inside_res});

   // receiver stall pattern, with an occasional long hold-off
   initial begin
      int mode, span;
      rsp_stall = 1;
      @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 80);
         if (hold_rsp) begin
            mode = 4;
            span = HOLD_CYCLES;
            hold_rsp = 0;
         end
         for (int k = 0; k < span; k++) begin
            case (mode)
               0: rsp_stall <= 0;
               1: rsp_stall <= ($urandom_range(0, 9) < 3);
               2: rsp_stall <= ($urandom_range(0, 9) < 8);
               3: rsp_stall <= k[2];
               default: rsp_stall <= 1;
            endcase
            @(negedge clock);
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      sb = new();
      burst_left  = 0;
      csr_writes  = 0;
      idle_cycles = 0;
      hold_rsp    = 0;
      reset          = 1;
      req_valid      = 0;
      req_action     = ACT_LOAD;
      req_load_index = '0;
      req_red_in     = '0;
      req_green_in   = '0;
      req_blue_in    = '0;
      req_alpha_in   = '0;
      req_out_col    = '0;
      req_out_row    = '0;
      csr_valid      = 0;
      csr_index      = CSR_SRC_W;
      csr_data       = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: default 1280x720 frame, corners, center, far positions
      render_pixel(0, 0);
      render_pixel(CANVAS_W - 1, CANVAS_H - 1);
      render_pixel(CANVAS_W / 2, CANVAS_H / 2);
      render_pixel(2047, 1023);
      render_pixel(0, CANVAS_H - 1);
      send_item(ACT_LOAD, 20'hFFFFF, 32'hFFFF_FFFF, 0, 0);      // past the frame, last store entry
      send_item(ACT_LOAD, 20'(1280 * 720), 32'h1234_5678, 0, 0); // past the frame
      send_item(ACT_LOAD, 20'd0, 32'h00FF_FFFF, 0, 0);          // transparent white
      send_item(ACT_RENDER, '0, '0, 0, 0);
      send_item(ACT_LOAD, 20'd0, 32'hFF00_0000, 0, 0);          // opaque black
      send_item(ACT_RENDER, '0, '0, 0, 0);
      send_item(ACT_LOAD, 20'd0, 32'hFFFF_FFFF, 0, 0);          // opaque white
      send_item(ACT_RENDER, '0, '0, 0, 0);
      drain();

      // tiny frames, saturated registers, unused index
      configure(1, 1, 4096, 0, 0);
      render_pixel(CANVAS_W / 2, CANVAS_H / 2);
      render_pixel(0, 0);
      drain();
      csr_write(CSR_UNUSED, '1);
      render_pixel(CANVAS_W / 2 - 1, CANVAS_H / 2);
      random_phase(60);
      drain();
      configure(0, 4095, 0, 18'h20000, 18'h1FFFF);
      random_phase(80);
      drain();

      // main random phases over a spread of settings
      configure(4, 3, 4096, 0, 0);
      hold_rsp = 1;
      random_phase(120);
      drain();
      configure(7, 5, 32768, -71680, 71680);
      random_phase(90);
      drain();
      configure(2048, 2048, 32768, 71680, -71680);
      random_phase(90);
      drain();
      configure(2048, 1, 65535, 0, 0);
      random_phase(80);
      drain();
      configure(1, 2048, 4096, -1, 1);
      random_phase(80);
      drain();
      configure($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(4096, 32768),
                $urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000);
      hold_rsp = 1;
      random_phase(120);
      drain();

      $display("covered %0d renders (%0d inside the image), %0d loads, %0d register writes",
               sb.renders, sb.inside_hits, sb.loads, csr_writes);
      if (sb.errors == 0 && sb.pixel_queue.size() == 0) begin
         $display("status: pass");
      end
      else begin
         $display("%0d mismatches, %0d pixels missing", sb.errors, sb.pixel_queue.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> bilinear_fit_zoom_pan_scaler.f
design/bfz_pkg.sv
design/bfz_setup.sv
design/bfz_map.sv
design/bfz_store.sv
design/bfz_blend.sv
design/bilinear_fit_zoom_pan_scaler.sv
dv/tb_bilinear_fit_zoom_pan_scaler.sv
